[hw/rtl/sagc_pkg.sv]
// Shared constants, types and gesture patterns of the six-axis gesture classifier.
`default_nettype none

package sagc_pkg;

  // Sample width default and register widths.
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int CFG_THR_BITS    = 10;
  localparam int CFG_INDEX_W     = 2;

  // Axes, levels and patterns.
  localparam int AXES         = 6;
  localparam int LEVEL_W      = 2;
  localparam int LEVELS_W     = AXES * LEVEL_W;
  localparam int NUM_PATTERNS = 10;
  localparam int CODE_W       = 4;

  // Reset values of the configuration registers.
  localparam int LOW_THR_RESET  = 290;
  localparam int HIGH_THR_RESET = 380;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LEFT_HAND      = 2'd2;

  // Level codes of one axis.
  localparam logic [LEVEL_W-1:0] LVL_ZERO  = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_PLUS  = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_MINUS = 2'd3;

  // Gesture codes.
  localparam logic [CODE_W-1:0] GEST_NONE = 4'd0;

  // Rows of the pattern table that trade places for the left hand.
  localparam int TAKE_ROW = 2;
  localparam int PUSH_ROW = 3;

  // Packed patterns, axis i in bits 2i+1..2i, in priority order (right hand).
  localparam logic [LEVELS_W-1:0] PATTERNS [NUM_PATTERNS] = '{
    12'h410,  // flat
    12'h110,  // bump
    12'h041,  // take
    12'h0C3,  // push
    12'h30C,  // stop
    12'h40C,  // revolution
    12'h510,  // down
    12'hC04,  // clench
    12'hC30,  // beg
    12'h330   // flex
  };

  // What the merging stage reports for one word.
  typedef struct packed {
    logic              changed;
    logic              emit;
    logic [CODE_W-1:0] code;
  } sagc_match_t;

endpackage

`default_nettype wire

[hw/rtl/sagc_if.sv]
// Channel interfaces of the six-axis gesture classifier: samples, results, configuration.
`default_nettype none

interface sagc_in_if #(
  parameter int SAMPLE_BITS = 10
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] palm_x_sample;
  logic [SAMPLE_BITS-1:0] palm_y_sample;
  logic [SAMPLE_BITS-1:0] palm_z_sample;
  logic [SAMPLE_BITS-1:0] knuckle_x_sample;
  logic [SAMPLE_BITS-1:0] knuckle_y_sample;
  logic [SAMPLE_BITS-1:0] knuckle_z_sample;

  modport source (
    output valid, palm_x_sample, palm_y_sample, palm_z_sample,
           knuckle_x_sample, knuckle_y_sample, knuckle_z_sample,
    input  ready
  );
  modport sink (
    input  valid, palm_x_sample, palm_y_sample, palm_z_sample,
           knuckle_x_sample, knuckle_y_sample, knuckle_z_sample,
    output ready
  );
endinterface

interface sagc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] gesture_code;

  modport source (output valid, gesture_code, input ready);
  modport sink (input valid, gesture_code, output ready);
endinterface

interface sagc_cfg_if #(
  parameter int DATA_W = 10
);
  logic              valid;
  logic              ready;
  logic [1:0]        index;
  logic [DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/six_axis_gesture_classifier_unit.sv]
// Top level of the six-axis gesture classifier: lanes, merging stage, state and output buffer.
//
//   channel   role      carries
//   -------   ------    ------------------------------------------------
//   samples   sink      six axis samples, palm X/Y/Z and knuckle X/Y/Z
//   gesture   source    gesture_code, sent only when the gesture changes
//   cfg       sink      index and data of a register write, always ready
//
// No register lies before the buffer: six lanes quantize a word, the merging stage matches
// it and the result lands in a two-entry output buffer at the clock edge that takes the word.
// One word per cycle is sustained; samples.ready drops only when both buffer
// entries hold results that the sink has not taken. Synchronous reset loads the
// threshold defaults, right hand, all-zero levels and gesture none.
`default_nettype none

module six_axis_gesture_classifier_unit #(
  parameter int SAMPLE_BITS = sagc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  sagc_in_if.sink     samples,
  sagc_out_if.source  gesture,
  sagc_cfg_if.sink    cfg
);
  import sagc_pkg::*;

  localparam int ThrW = (SAMPLE_BITS > CFG_THR_BITS) ? SAMPLE_BITS : CFG_THR_BITS;

  // Configuration registers.
  logic [ThrW-1:0] low_threshold;
  logic [ThrW-1:0] high_threshold;
  logic            left_hand;

  // Classifier state.
  logic [LEVELS_W-1:0] last_levels;
  logic [CODE_W-1:0]   last_gesture;

  // Output buffer: head register and skid entry.
  logic              head_valid;
  logic [CODE_W-1:0] head_code;
  logic              skid_valid;
  logic [CODE_W-1:0] skid_code;

  logic [SAMPLE_BITS-1:0] sample_vec [AXES];
  logic [LEVELS_W-1:0]    levels;
  sagc_match_t            match;
  logic                   accept;
  logic                   push;
  logic                   pop;

  assign sample_vec[0] = samples.palm_x_sample;
  assign sample_vec[1] = samples.palm_y_sample;
  assign sample_vec[2] = samples.palm_z_sample;
  assign sample_vec[3] = samples.knuckle_x_sample;
  assign sample_vec[4] = samples.knuckle_y_sample;
  assign sample_vec[5] = samples.knuckle_z_sample;

  // One quantizer lane per axis.
  for (genvar g = 0; g < AXES; g++) begin : g_lane
    sagc_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .sample         (sample_vec[g]),
      .low_threshold  (low_threshold),
      .high_threshold (high_threshold),
      .level          (levels[g*LEVEL_W +: LEVEL_W])
    );
  end

  sagc_merge u_merge (
    .levels       (levels),
    .last_levels  (last_levels),
    .last_gesture (last_gesture),
    .left_hand    (left_hand),
    .match        (match)
  );

  // Handshakes.
  assign samples.ready = !skid_valid;
  assign accept        = samples.valid && !skid_valid;
  assign push          = accept && match.emit;
  assign pop           = head_valid && gesture.ready;

  assign gesture.valid        = head_valid;
  assign gesture.gesture_code = head_code;
  assign cfg.ready            = 1'b1;

  // Register writes keep the low sample bits of a threshold.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_threshold  <= ThrW'(LOW_THR_RESET);
      high_threshold <= ThrW'(HIGH_THR_RESET);
      left_hand      <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_LOW_THRESHOLD:  low_threshold  <= ThrW'(SAMPLE_BITS'(cfg.data));
        REG_HIGH_THRESHOLD: high_threshold <= ThrW'(SAMPLE_BITS'(cfg.data));
        REG_LEFT_HAND:      left_hand      <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // Last levels and last reported gesture follow each accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_levels  <= '0;
      last_gesture <= GEST_NONE;
    end else if (accept) begin
      if (match.changed) begin
        last_levels <= levels;
      end
      if (match.emit) begin
        last_gesture <= match.code;
      end
    end
  end

  // Two-entry output buffer; a push never arrives while the skid entry is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  // Payload of the buffer entries.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head_code <= skid_code;
        skid_code <= match.code;
      end else begin
        head_code <= match.code;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_code <= match.code;
      end else begin
        head_code <= match.code;
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sagc_lane.sv]
// One axis lane: quantizes a sample to a level against the two thresholds.
`default_nettype none

module sagc_lane #(
  parameter int SAMPLE_BITS = sagc_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [((SAMPLE_BITS > sagc_pkg::CFG_THR_BITS) ?
                      SAMPLE_BITS : sagc_pkg::CFG_THR_BITS)-1:0] low_threshold,
  input  wire logic [((SAMPLE_BITS > sagc_pkg::CFG_THR_BITS) ?
                      SAMPLE_BITS : sagc_pkg::CFG_THR_BITS)-1:0] high_threshold,
  output logic [sagc_pkg::LEVEL_W-1:0]  level
);
  import sagc_pkg::*;

  localparam int ThrW = (SAMPLE_BITS > CFG_THR_BITS) ? SAMPLE_BITS : CFG_THR_BITS;

  logic [ThrW-1:0] sample_ext;

  assign sample_ext = ThrW'(sample);

  // Below low gives minus one, else below high gives zero, else plus one.
  always_comb begin
    priority if (sample_ext < low_threshold) begin
      level = LVL_MINUS;
    end else if (sample_ext < high_threshold) begin
      level = LVL_ZERO;
    end else begin
      level = LVL_PLUS;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sagc_merge.sv]
// Merging stage: change detection, pattern match over the lane levels, and emit decision.
`default_nettype none

module sagc_merge (
  input  wire logic [sagc_pkg::LEVELS_W-1:0] levels,
  input  wire logic [sagc_pkg::LEVELS_W-1:0] last_levels,
  input  wire logic [sagc_pkg::CODE_W-1:0]   last_gesture,
  input  wire logic                          left_hand,
  output sagc_pkg::sagc_match_t              match
);
  import sagc_pkg::*;

  logic [NUM_PATTERNS-1:0] hit;
  logic [CODE_W-1:0]       code;

  // Compare against every pattern at once; take and push trade rows for the left hand.
  always_comb begin
    for (int i = 0; i < NUM_PATTERNS; i++) begin
      if (left_hand && i == TAKE_ROW) begin
        hit[i] = (levels == PATTERNS[PUSH_ROW]);
      end else if (left_hand && i == PUSH_ROW) begin
        hit[i] = (levels == PATTERNS[TAKE_ROW]);
      end else begin
        hit[i] = (levels == PATTERNS[i]);
      end
    end
  end

  // Lowest matching row wins; the scan runs downward so the last write has priority.
  always_comb begin
    code = GEST_NONE;
    for (int i = NUM_PATTERNS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        code = CODE_W'(i + 1);
      end
    end
  end

  assign match.changed = (levels != last_levels);
  assign match.emit    = match.changed && (code != last_gesture);
  assign match.code    = code;

endmodule

`default_nettype wire

[bench/tb_top.sv]
// Self-checking testbench of the six-axis gesture classifier, with a scoreboard class.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sagc_pkg::*;

  localparam int SAMPLE_BITS = SAMPLE_BITS_DEF;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
  localparam int STALL_LIMIT = 2000;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t word_t [AXES];
  typedef int levels_t [AXES];

  // Scoreboard: its own copy of the registers and state, and the codes still owed.
  class gesture_board;
    logic [CFG_THR_BITS-1:0] low_thr;
    logic [CFG_THR_BITS-1:0] high_thr;
    logic                    left_hand;
    logic [LEVELS_W-1:0]     last_levels;
    logic [CODE_W-1:0]       last_code;
    logic [CODE_W-1:0]       owed_codes [$];
    int                      failures;

    function new();
      low_thr     = CFG_THR_BITS'(LOW_THR_RESET);
      high_thr    = CFG_THR_BITS'(HIGH_THR_RESET);
      left_hand   = 1'b0;
      last_levels = '0;
      last_code   = GEST_NONE;
      failures    = 0;
    endfunction

    // Level, -1, 0 or +1, of one axis in one gesture shape (right hand order).
    static function int shape_level(int row, int axis);
      int lv [AXES];
      case (row)
        0: lv = '{0, 0, 1, 0, 0, 1};    // flat
        1: lv = '{0, 0, 1, 0, 1, 0};    // bump
        2: lv = '{1, 0, 0, 1, 0, 0};    // take
        3: lv = '{-1, 0, 0, -1, 0, 0};  // push
        4: lv = '{0, -1, 0, 0, -1, 0};  // stop
        5: lv = '{0, -1, 0, 0, 0, 1};   // revolution
        6: lv = '{0, 0, 1, 0, 1, 1};    // down
        7: lv = '{0, 1, 0, 0, 0, -1};   // clench
        8: lv = '{0, 0, -1, 0, 0, -1};  // beg
        9: lv = '{0, 0, -1, 0, -1, 0};  // flex
        default: lv = '{0, 0, 0, 0, 0, 0};
      endcase
      return lv[axis];
    endfunction

    function logic [LEVEL_W-1:0] level_bits(int lv);
      if (lv < 0) return LVL_MINUS;
      if (lv > 0) return LVL_PLUS;
      return LVL_ZERO;
    endfunction

    function logic [LEVELS_W-1:0] shape_bits(int row);
      logic [LEVELS_W-1:0] bits;
      bits = '0;
      for (int a = 0; a < AXES; a++) bits[LEVEL_W*a +: LEVEL_W] = level_bits(shape_level(row, a));
      return bits;
    endfunction

    // Tests run in a fixed order even when the thresholds are out of order.
    function logic [LEVEL_W-1:0] quantize(sample_t s);
      if (s < low_thr) return LVL_MINUS;
      if (s < high_thr) return LVL_ZERO;
      return LVL_PLUS;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_THR_BITS-1:0] data);
      case (idx)
        REG_LOW_THRESHOLD:  low_thr = data;
        REG_HIGH_THRESHOLD: high_thr = data;
        REG_LEFT_HAND:      left_hand = data[0];
        default: ;
      endcase
    endfunction

    // Classify one accepted word and note the code it owes, if any.
    function void note_word(word_t w);
      logic [LEVELS_W-1:0] cur;
      logic [CODE_W-1:0]   code;
      logic                found;
      int                  r;
      cur = '0;
      for (int a = 0; a < AXES; a++) cur[LEVEL_W*a +: LEVEL_W] = quantize(w[a]);
      if (cur == last_levels) return;
      last_levels = cur;
      code  = GEST_NONE;
      found = 1'b0;
      for (int row = 0; row < NUM_PATTERNS; row++) begin
        r = row;
        if (left_hand && row == TAKE_ROW) r = PUSH_ROW;
        else if (left_hand && row == PUSH_ROW) r = TAKE_ROW;
        if (!found && shape_bits(r) == cur) begin
          code  = CODE_W'(row + 1);
          found = 1'b1;
        end
      end
      if (code == last_code) return;
      last_code = code;
      owed_codes.push_back(code);
    endfunction

    function void check_code(logic [CODE_W-1:0] got);
      logic [CODE_W-1:0] want;
      if (owed_codes.size() == 0) begin
        $error("unexpected gesture word: gesture_code=%0d", got);
        failures++;
        return;
      end
      want = owed_codes.pop_front();
      if (want !== got) begin
        $error("gesture_code: expected %0d, actual %0d", want, got);
        failures++;
      end
    endfunction

    function int owed();
      return owed_codes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  sagc_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples_ch ();
  sagc_out_if                             gesture_ch ();
  sagc_cfg_if #(.DATA_W(CFG_THR_BITS))    cfg_ch ();

  six_axis_gesture_classifier_unit #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_ch),
    .gesture (gesture_ch),
    .cfg     (cfg_ch)
  );

  gesture_board sb;
  int src_idle_pct;
  int snk_idle_pct;
  int stall_cycles;
  levels_t prev_lv;

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result sink: ready toggles at random at the falling edge.
  initial begin
    gesture_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      gesture_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Check each accepted gesture word against the oldest owed code.
  always @(posedge clk) begin
    if (!rst && gesture_ch.valid && gesture_ch.ready) sb.check_code(gesture_ch.gesture_code);
  end

  // Watchdog on cycles in which no channel moves a word.
  always @(posedge clk) begin
    if (rst || (samples_ch.valid && samples_ch.ready) || (gesture_ch.valid && gesture_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // A sample that quantizes to the wanted level under the current thresholds, if any can; else random.
  // Pick 0 lands on a boundary, pick 1 on the far end, anything else is random.
  function sample_t level_sample(int lv, int pick);
    int lo;
    int hi;
    int top;
    lo  = int'(sb.low_thr);
    hi  = int'(sb.high_thr);
    top = (lo > hi) ? lo : hi;
    if (lv < 0) begin
      if (lo == 0) return sample_t'($urandom_range(0, SAMPLE_MAX));
      if (pick == 0) return sample_t'(lo - 1);
      if (pick == 1) return '0;
      return sample_t'($urandom_range(0, lo - 1));
    end
    if (lv == 0) begin
      if (lo >= hi) return sample_t'($urandom_range(0, SAMPLE_MAX));
      if (pick == 0) return sample_t'(lo);
      if (pick == 1) return sample_t'(hi - 1);
      return sample_t'($urandom_range(lo, hi - 1));
    end
    if (pick == 0) return sample_t'(top);
    if (pick == 1) return sample_t'(SAMPLE_MAX);
    return sample_t'($urandom_range(top, SAMPLE_MAX));
  endfunction

  function word_t make_word(levels_t lv, int pick);
    word_t w;
    for (int a = 0; a < AXES; a++) w[a] = level_sample(lv[a], pick);
    return w;
  endfunction

  // Offer one sample word, idling at random first, and note it once taken.
  task automatic send_word(word_t w);
    @(negedge clk);
    while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      samples_ch.valid <= 1'b0;
      @(negedge clk);
    end
    samples_ch.valid            <= 1'b1;
    samples_ch.palm_x_sample    <= w[0];
    samples_ch.palm_y_sample    <= w[1];
    samples_ch.palm_z_sample    <= w[2];
    samples_ch.knuckle_x_sample <= w[3];
    samples_ch.knuckle_y_sample <= w[4];
    samples_ch.knuckle_z_sample <= w[5];
    do @(posedge clk); while (!samples_ch.ready);
    sb.note_word(w);
  endtask

  task automatic send_shape(int row, int pick);
    levels_t lv;
    for (int a = 0; a < AXES; a++) lv[a] = gesture_board::shape_level(row, a);
    send_word(make_word(lv, pick));
  endtask

  task automatic send_uniform(int level, int pick);
    levels_t lv;
    for (int a = 0; a < AXES; a++) lv[a] = level;
    send_word(make_word(lv, pick));
  endtask

  // Let the block go idle: no word offered and every owed code delivered.
  task automatic settle();
    @(negedge clk);
    samples_ch.valid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_THR_BITS-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Write all registers; the hand bit rides on random upper bits.
  task automatic set_config(int lo, int hi, logic left);
    logic [CFG_THR_BITS-1:0] hand;
    hand    = CFG_THR_BITS'($urandom_range(0, SAMPLE_MAX));
    hand[0] = left;
    write_reg(REG_LOW_THRESHOLD, CFG_THR_BITS'(lo));
    write_reg(REG_HIGH_THRESHOLD, CFG_THR_BITS'(hi));
    write_reg(REG_LEFT_HAND, hand);
    write_reg(REG_UNUSED, CFG_THR_BITS'($urandom_range(0, SAMPLE_MAX)));
  endtask

  // Random words: mostly gesture shapes and repeats, some random levels and raw noise.
  task automatic run_phase(int count, int src_pct, int snk_pct);
    levels_t lv;
    word_t   w;
    int      r;
    int      row;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (r < 10) begin
        for (int a = 0; a < AXES; a++) w[a] = sample_t'($urandom_range(0, SAMPLE_MAX));
      end else begin
        if (r < 22) begin
          lv = prev_lv;
        end else if (r < 75) begin
          row = $urandom_range(0, NUM_PATTERNS - 1);
          for (int a = 0; a < AXES; a++) lv[a] = gesture_board::shape_level(row, a);
        end else begin
          for (int a = 0; a < AXES; a++) lv[a] = int'($urandom_range(0, 2)) - 1;
        end
        prev_lv = lv;
        for (int a = 0; a < AXES; a++) w[a] = level_sample(lv[a], $urandom_range(0, 2));
      end
      send_word(w);
    end
    settle();
  endtask

  // Main sequence: reset, directed words, then random phases over several settings.
  initial begin
    sb = new();
    rst = 1'b1;
    samples_ch.valid            = 1'b0;
    samples_ch.palm_x_sample    = '0;
    samples_ch.palm_y_sample    = '0;
    samples_ch.palm_z_sample    = '0;
    samples_ch.knuckle_x_sample = '0;
    samples_ch.knuckle_y_sample = '0;
    samples_ch.knuckle_z_sample = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    src_idle_pct = 35;
    snk_idle_pct = 35;
    for (int a = 0; a < AXES; a++) prev_lv[a] = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part on the reset settings: an all-zero first word counts as unchanged.
    send_uniform(0, 2);
    for (int row = 0; row < NUM_PATTERNS; row++) send_shape(row, row % 2);
    send_shape(NUM_PATTERNS - 1, 2);
    send_shape(0, 1);
    send_uniform(1, 1);
    send_uniform(-1, 1);
    send_uniform(0, 0);
    send_shape(1, 0);
    settle();

    // The left hand swaps take and push.
    write_reg(REG_LEFT_HAND, CFG_THR_BITS'(1));
    send_shape(TAKE_ROW, 0);
    send_shape(PUSH_ROW, 1);
    settle();
    write_reg(REG_LEFT_HAND, CFG_THR_BITS'(10'h3FE));
    write_reg(REG_UNUSED, CFG_THR_BITS'(SAMPLE_MAX));
    send_shape(TAKE_ROW, 1);
    send_shape(PUSH_ROW, 0);
    settle();

    // Random phases, one of them without any idling.
    run_phase(250, 35, 35);
    set_config(LOW_THR_RESET, HIGH_THR_RESET, 1'b1);
    run_phase(200, 0, 0);
    set_config(0, SAMPLE_MAX, 1'b0);
    run_phase(100, 35, 35);
    set_config(SAMPLE_MAX, 0, 1'b1);
    run_phase(100, 35, 35);
    set_config(700, 300, 1'b0);
    run_phase(150, 35, 35);
    set_config(100, 900, 1'b1);
    run_phase(200, 35, 35);
    set_config($urandom_range(0, SAMPLE_MAX), $urandom_range(0, SAMPLE_MAX), $urandom_range(0, 1));
    run_phase(150, 35, 35);
    set_config(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
    run_phase(100, 35, 35);

    // Drain and report.
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.owed() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/sagc_pkg.sv
hw/rtl/sagc_if.sv
hw/rtl/sagc_lane.sv
hw/rtl/sagc_merge.sv
hw/rtl/six_axis_gesture_classifier_unit.sv
bench/tb_top.sv
